// ===== rtl/odd_pkg.sv =====
// Shared widths, constants and types of the odometer drum driver.
package odd_pkg;

    localparam int ANGLE_W    = 32;
    localparam int RADIUS_W   = 20;
    localparam int MAG_W      = 19;
    localparam int FACTOR_W   = 27;
    localparam int DIV_W      = RADIUS_W + FACTOR_W;
    localparam int QUO_W      = 40;
    localparam int ACC_W      = 44;
    localparam int FRAC_BITS  = 24;
    localparam int DISP_W     = ACC_W - FRAC_BITS;
    localparam int DIGIT_W    = 4;
    localparam int ROLL_FIELDS = 6;
    localparam int DRUM_COUNT_DEF = 6;
    localparam int Q_DEPTH    = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [MAG_W:0]      WRAP_GUARD   = 20'd327680;
    localparam logic [RADIUS_W-1:0] RADIUS_DEF   = 20'd22938;
    localparam logic [FACTOR_W-1:0] FACTOR_MILES = 27'd535429;
    localparam logic [FACTOR_W-1:0] FACTOR_KPH   = 27'd86150545;
    localparam logic [DISP_W-1:0]   DIST_WRAP    = 20'd1000000;
    localparam logic [ACC_W:0]      DIST_WRAP_FX = (ACC_W+1)'(DIST_WRAP) << FRAC_BITS;
    localparam logic [DISP_W-1:0]   RECIP10      = 20'd838861;
    localparam int                  RECIP_SHIFT  = 23;
    localparam logic [DIGIT_W-1:0]  DIGIT_BASE   = 4'd10;

    typedef enum logic [0:0] {
        REG_RADIUS = 1'b0,
        REG_KPH    = 1'b1
    } t_reg;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [DIV_W-1:0] divisor;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/odd_front.sv =====
// Front end: takes angle beats, forms the guarded magnitude and the divisor.
module odd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [odd_pkg::ANGLE_W-1:0]  i_wheel_angle,
    input  logic [odd_pkg::RADIUS_W-1:0] i_radius,
    input  logic                         i_kph,
    input  odd_pkg::t_qstat              i_qstat,
    output logic                         o_wr,
    output odd_pkg::t_job                o_job
);
    import odd_pkg::*;

    logic [ANGLE_W-1:0]  r_last_angle;
    logic                r_vld;
    logic [MAG_W-1:0]    r_mag;
    logic [RADIUS_W-1:0] r_radius;
    logic                r_kph;

    logic                w_accept;
    logic signed [ANGLE_W:0] w_diff;
    logic [ANGLE_W:0]    w_abs;
    logic [MAG_W-1:0]    n_mag;
    logic [FACTOR_W-1:0] w_factor;

    assign o_full   = r_vld && i_qstat.full;
    assign w_accept = i_push && !o_full;
    assign o_wr     = r_vld && !i_qstat.full;

    assign w_diff = $signed({i_wheel_angle[ANGLE_W-1], i_wheel_angle})
                  - $signed({r_last_angle[ANGLE_W-1], r_last_angle});
    assign w_abs  = w_diff[ANGLE_W] ? (ANGLE_W+1)'(-w_diff) : (ANGLE_W+1)'(w_diff);
    // drop jumps past the wrap guard
    assign n_mag  = (w_abs > (ANGLE_W+1)'(WRAP_GUARD)) ? '0 : w_abs[MAG_W-1:0];

    assign w_factor      = r_kph ? FACTOR_KPH : FACTOR_MILES;
    assign o_job.mag     = r_mag;
    assign o_job.divisor = DIV_W'(r_radius) * DIV_W'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_vld        <= 1'b0;
        end else begin
            if (w_accept) begin
                r_last_angle <= i_wheel_angle;
                r_vld        <= 1'b1;
            end else if (o_wr) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag    <= n_mag;
            r_radius <= (i_radius == '0) ? RADIUS_DEF : i_radius;
            r_kph    <= i_kph;
        end
    end

endmodule

// ===== rtl/odd_fifo.sv =====
// Short job queue between the front end and the back end.
module odd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  odd_pkg::t_job   i_job,
    input  logic            i_rd,
    output odd_pkg::t_job   o_job,
    output odd_pkg::t_qstat o_qstat
);
    import odd_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_qstat.full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_wr  = i_wr && !o_qstat.full;
    assign w_rd  = i_rd && !o_qstat.empty;
    assign o_job = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== rtl/odd_back.sv =====
// Back end: bit-serial divide, distance accumulate, digit split and drum rolls.
module odd_back #(
    parameter int DRUM_COUNT = odd_pkg::DRUM_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  odd_pkg::t_qstat            i_qstat,
    input  odd_pkg::t_job              i_job,
    output logic                       o_rd,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [odd_pkg::DISP_W-1:0] o_display,
    output logic [odd_pkg::ROLL_FIELDS-1:0][odd_pkg::DIGIT_W-1:0] o_rolls
);
    import odd_pkg::*;

    localparam int DCNT_W = (DRUM_COUNT > 1) ? $clog2(DRUM_COUNT) : 1;
    localparam int BCNT_W = $clog2(QUO_W);
    localparam int REM_W  = DIV_W + 1;
    localparam int PROD_W = 2 * DISP_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_DIG  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [QUO_W-1:0]     r_quo;
    logic [BCNT_W-1:0]    r_bcnt;
    logic [DCNT_W-1:0]    r_dcnt;
    logic [ACC_W-1:0]     r_acc;
    logic [DISP_W-1:0]    r_disp;
    logic [DISP_W-1:0]    r_x;
    logic [DIGIT_W-1:0]   r_shown [DRUM_COUNT];
    logic [DIGIT_W-1:0]   r_roll  [DRUM_COUNT];
    logic                 r_ovld;

    logic [REM_W-1:0]     w_rem2;
    logic                 w_qbit;
    logic [ACC_W:0]       w_sum;
    logic [ACC_W:0]       n_sum;
    logic [PROD_W-1:0]    w_prod;
    logic [DISP_W-1:0]    w_q10;
    logic [DISP_W-1:0]    w_q10x;
    logic [DISP_W-1:0]    w_rem10;
    logic [DIGIT_W-1:0]   w_digit;
    logic [DIGIT_W-1:0]   w_old;
    logic [DIGIT_W-1:0]   w_roll;
    logic                 w_load_out;

    assign o_rd    = (r_state == ST_IDLE) && !i_qstat.empty;
    assign o_empty = !r_ovld;
    assign w_load_out = (r_state == ST_DONE) && (!r_ovld || i_pop);

    assign w_rem2 = {r_rem[REM_W-2:0], 1'b0};
    assign w_qbit = (w_rem2 >= REM_W'(r_div));

    assign w_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_quo);
    assign n_sum = (w_sum[ACC_W:FRAC_BITS] >= (ACC_W+1-FRAC_BITS)'(DIST_WRAP))
                 ? w_sum - DIST_WRAP_FX : w_sum;

    assign w_prod  = PROD_W'(r_x) * PROD_W'(RECIP10);
    assign w_q10   = DISP_W'(w_prod >> RECIP_SHIFT);
    assign w_q10x  = (w_q10 << 3) + (w_q10 << 1);
    assign w_rem10 = r_x - w_q10x;
    assign w_digit = w_rem10[DIGIT_W-1:0];
    assign w_old   = r_shown[DRUM_COUNT-1];
    assign w_roll  = (w_digit >= w_old) ? w_digit - w_old : w_digit + DIGIT_BASE - w_old;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bcnt == BCNT_W'(QUO_W - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = ST_DIG;
            ST_DIG: begin
                if (r_dcnt == DCNT_W'(DRUM_COUNT - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_ovld  <= 1'b0;
            for (int j = 0; j < DRUM_COUNT; j++) begin
                r_shown[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                r_acc <= n_sum[ACC_W-1:0];
            end
            if (r_state == ST_DIG) begin
                r_shown[0] <= w_digit;
                for (int j = 1; j < DRUM_COUNT; j++) begin
                    r_shown[j] <= r_shown[j-1];
                end
            end
            if (w_load_out) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rem  <= REM_W'(i_job.mag);
                r_div  <= i_job.divisor;
                r_quo  <= '0;
                r_bcnt <= '0;
            end
            ST_DIV: begin
                r_rem  <= w_qbit ? w_rem2 - REM_W'(r_div) : w_rem2;
                r_quo  <= {r_quo[QUO_W-2:0], w_qbit};
                r_bcnt <= r_bcnt + 1'b1;
            end
            ST_ACC: begin
                r_disp <= n_sum[ACC_W-1:FRAC_BITS];
                r_x    <= n_sum[ACC_W-1:FRAC_BITS];
                r_dcnt <= '0;
            end
            ST_DIG: begin
                r_x       <= w_q10;
                r_dcnt    <= r_dcnt + 1'b1;
                r_roll[0] <= w_roll;
                for (int j = 1; j < DRUM_COUNT; j++) begin
                    r_roll[j] <= r_roll[j-1];
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    o_display <= r_disp;
                    for (int f = 0; f < ROLL_FIELDS; f++) begin
                        o_rolls[f] <= (f < DRUM_COUNT) ? r_roll[f % DRUM_COUNT] : '0;
                    end
                end
            end
            default: begin
                r_bcnt <= '0;
            end
        endcase
    end

endmodule

// ===== rtl/odometer_digit_drum_driver.sv =====
// Odometer drum driver top level: config registers, front end, queue and back end.
//
//  channel   | ports                              | beat when
//  ----------+------------------------------------+---------------------------------
//  angle in  | push, full, i_wheel_angle          | push & !full
//  result    | pop, empty, o_display_value, o_roll_* | pop & !empty
//  config    | psel, penable, pwrite, paddr, pwdata, prdata, pready | psel & penable & pwrite
//
//  The back end takes one item at a time: a load step, the one-bit-a-cycle divider
//  for 40 quotient bits, an accumulate step, a digit-splitter step per drum and a
//  hand-off step. The divider loop sets the rate. The front end registers beats and,
//  with the two-entry queue, keeps taking them while the back end works, until it is full.
//  An unread result holds the back end in its hand-off step until pop.
//  Reset is synchronous, clears distance, last angle and shown digits, restores registers.
module odometer_digit_drum_driver #(
    parameter int DRUM_COUNT = odd_pkg::DRUM_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [odd_pkg::PADDR_W-1:0]   paddr,
    input  logic [odd_pkg::PDATA_W-1:0]   pwdata,
    output logic [odd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic signed [odd_pkg::ANGLE_W-1:0] i_wheel_angle,
    output logic                          empty,
    input  logic                          pop,
    output logic [odd_pkg::DISP_W-1:0]    o_display_value,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_hundred_thousands,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_ten_thousands,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_thousands,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_hundreds,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_tens,
    output logic [odd_pkg::DIGIT_W-1:0]   o_roll_units
);
    import odd_pkg::*;

    logic [RADIUS_W-1:0] r_wheel_radius;
    logic                r_kph_mode;
    logic                w_cfg_wr;
    t_reg                w_reg;

    t_qstat              w_qstat;
    logic                w_q_wr;
    logic                w_q_rd;
    t_job                w_wr_job;
    t_job                w_rd_job;
    logic [ROLL_FIELDS-1:0][DIGIT_W-1:0] w_rolls;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg'(paddr[2]);

    always_comb begin
        unique case (w_reg)
            REG_RADIUS: prdata = PDATA_W'(r_wheel_radius);
            REG_KPH:    prdata = PDATA_W'(r_kph_mode);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius <= RADIUS_DEF;
            r_kph_mode     <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_RADIUS: r_wheel_radius <= pwdata[RADIUS_W-1:0];
                REG_KPH:    r_kph_mode     <= pwdata[0];
                default:    r_kph_mode     <= r_kph_mode;
            endcase
        end
    end

    odd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_wheel_angle (i_wheel_angle),
        .i_radius      (r_wheel_radius),
        .i_kph         (r_kph_mode),
        .i_qstat       (w_qstat),
        .o_wr          (w_q_wr),
        .o_job         (w_wr_job)
    );

    odd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_job   (w_wr_job),
        .i_rd    (w_q_rd),
        .o_job   (w_rd_job),
        .o_qstat (w_qstat)
    );

    odd_back #(
        .DRUM_COUNT (DRUM_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qstat   (w_qstat),
        .i_job     (w_rd_job),
        .o_rd      (w_q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_display (o_display_value),
        .o_rolls   (w_rolls)
    );

    assign o_roll_hundred_thousands = w_rolls[0];
    assign o_roll_ten_thousands     = w_rolls[1];
    assign o_roll_thousands         = w_rolls[2];
    assign o_roll_hundreds          = w_rolls[3];
    assign o_roll_tens              = w_rolls[4];
    assign o_roll_units             = w_rolls[5];

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_display_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_display_value < DIST_WRAP))
        else $error("display value past wrap");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_roll_hundred_thousands < DIGIT_BASE) && (o_roll_units < DIGIT_BASE)
                   && (o_roll_tens < DIGIT_BASE) && (o_roll_thousands < DIGIT_BASE))
        else $error("drum roll out of range");

    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_qstat.empty)
        else $error("queue status inconsistent");

endmodule
